// ===== hw/rtl/lsd_pkg.sv =====
// Shared constants, types and state encodings for the decimal radix sorter.
`default_nettype none

package lsd_pkg;

    // Buffer geometry.
    localparam int LSD_MAX_ITEMS = 64;
    localparam int LSD_IDX_W     = $clog2(LSD_MAX_ITEMS);
    localparam int LSD_CNT_W     = $clog2(LSD_MAX_ITEMS + 1);

    // Value and decimal digit geometry.
    localparam int LSD_VAL_W     = 31;
    localparam int LSD_RADIX     = 10;
    localparam int LSD_DIGITS    = 10;
    localparam int LSD_DIG_W     = 4;
    localparam int LSD_BCD_W     = LSD_DIGITS * LSD_DIG_W;
    localparam int LSD_PASS_W    = 4;

    // Division by ten through a reciprocal: floor(x * 0xCCCCCCCD / 2^35).
    localparam int          LSD_RECIP_W     = 32;
    localparam int          LSD_PROD_W      = LSD_VAL_W + LSD_RECIP_W;
    localparam int          LSD_RECIP_SHIFT = 35;
    localparam int          LSD_QUO_W       = LSD_PROD_W - LSD_RECIP_SHIFT;
    localparam logic [31:0] LSD_RECIP10     = 32'hCCCC_CCCD;

    // One buffer entry: the value with its decimal digits alongside.
    typedef struct packed {
        logic [LSD_BCD_W-1:0] bcd;
        logic [LSD_VAL_W-1:0] value;
    } t_entry;

    // Result of the digit unit towards the sequencer.
    typedef struct packed {
        logic                  done;
        logic [LSD_PASS_W-1:0] ndig;
        logic [LSD_BCD_W-1:0]  bcd;
    } t_conv_out;

    // Main sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_CHECK,
        S_COUNT,
        S_PREFIX,
        S_SCATTER,
        S_OUT
    } t_state;

    // Digit unit states.
    typedef enum logic [1:0] {
        CV_IDLE,
        CV_MUL,
        CV_DIG,
        CV_DONE
    } t_conv_state;

endpackage

`default_nettype wire

// ===== hw/rtl/lsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/lsd_bcd_conv.sv =====
// Iterative binary to decimal digit unit built around one reciprocal multiplier.
`default_nettype none

module lsd_bcd_conv
    import lsd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [LSD_VAL_W-1:0] i_value,
    output t_conv_out                 o_res
);

    t_conv_state r_state, n_state;

    logic [LSD_VAL_W-1:0]  r_q,    n_q;
    logic [LSD_PROD_W-1:0] r_prod, n_prod;
    logic [LSD_PASS_W-1:0] r_k,    n_k;
    logic [LSD_PASS_W-1:0] r_ndig, n_ndig;
    logic [LSD_BCD_W-1:0]  r_bcd,  n_bcd;

    logic [LSD_QUO_W-1:0]  quo;
    logic [LSD_VAL_W-1:0]  quo_ext;
    logic [LSD_VAL_W-1:0]  rem_full;

    // Quotient from the registered product, remainder by shift and add.
    assign quo      = r_prod[LSD_RECIP_SHIFT +: LSD_QUO_W];
    assign quo_ext  = LSD_VAL_W'(quo);
    assign rem_full = r_q - ((quo_ext << 3) + (quo_ext << 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            CV_IDLE: begin
                if (i_start) begin
                    n_state = (i_value == '0) ? CV_DONE : CV_MUL;
                end
            end
            CV_MUL:  n_state = CV_DIG;
            CV_DIG: begin
                n_state = (quo == '0) ? CV_DONE : CV_MUL;
            end
            CV_DONE: n_state = CV_IDLE;
            default: n_state = CV_IDLE;
        endcase
    end

    // Datapath: a multiply state, then a digit state, for each decimal digit.
    always_comb begin
        n_q    = r_q;
        n_prod = r_prod;
        n_k    = r_k;
        n_ndig = r_ndig;
        n_bcd  = r_bcd;
        case (r_state)
            CV_IDLE: begin
                if (i_start) begin
                    n_q    = i_value;
                    n_k    = '0;
                    n_ndig = '0;
                    n_bcd  = '0;
                end
            end
            CV_MUL: begin
                n_prod = LSD_PROD_W'(r_q) * LSD_PROD_W'(LSD_RECIP10);
            end
            CV_DIG: begin
                n_bcd[{r_k, 2'b00} +: LSD_DIG_W] = rem_full[LSD_DIG_W-1:0];
                n_q = quo_ext;
                if (quo == '0) begin
                    n_ndig = r_k + LSD_PASS_W'(1);
                end else begin
                    n_k = r_k + LSD_PASS_W'(1);
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
            r_k     <= '0;
            r_ndig  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ndig  <= n_ndig;
        end
        r_q    <= n_q;
        r_prod <= n_prod;
        r_bcd  <= n_bcd;
    end

    // Outputs.
    always_comb begin
        o_res.done = (r_state == CV_DONE);
        o_res.ndig = r_ndig;
        o_res.bcd  = r_bcd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lsd_decimal_radix_sort.sv =====
// Top level of the decimal LSD radix sorter: sequencer, digit counters and two buffers.
//
//   Channel   Direction  Handshake                         Ports
//   -------   ---------  --------------------------------  ------------------------------
//   load      in         i_start high while o_busy is low  i_value, i_last
//   result    out        o_valid strobe, one cycle each    o_sorted_value, o_last_out
//
// Loading a value runs the digit unit through a multiply and a digit state for each decimal
// digit of that value, or straight to done for a zero; the single reciprocal multiplier of
// the digit unit sets this pace. On a closing transaction each pass over n stored values
// handles one decimal digit of the largest value, in count, prefix and scatter phases
// limited by the one read port of each buffer; the output gives one result per cycle.
// Reset is synchronous and active low; the buffers hold no reset state. The receiver
// cannot stall: results leave on the strobe cycle.
`default_nettype none

module lsd_decimal_radix_sort
    import lsd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [LSD_VAL_W-1:0] i_value,
    input  wire logic                 i_last,
    output logic                      o_busy,
    output logic                      o_valid,
    output logic [LSD_VAL_W-1:0]      o_sorted_value,
    output logic                      o_last_out
);

    t_state r_state, n_state;

    logic [LSD_CNT_W-1:0]  r_count,   n_count;
    logic [LSD_PASS_W-1:0] r_max_dig, n_max_dig;
    logic                  r_last,    n_last;
    logic [LSD_VAL_W-1:0]  r_value,   n_value;
    logic [LSD_PASS_W-1:0] r_pass,    n_pass;
    logic                  r_src,     n_src;
    logic [LSD_CNT_W-1:0]  r_idx,     n_idx;
    logic                  r_pend,    n_pend;
    logic [LSD_PASS_W-1:0] r_j,       n_j;
    logic [LSD_CNT_W-1:0]  r_run,     n_run;
    logic [LSD_CNT_W-1:0]  r_cnt [LSD_RADIX];
    logic [LSD_CNT_W-1:0]  n_cnt [LSD_RADIX];

    logic                  r_out_valid, n_out_valid;
    logic [LSD_VAL_W-1:0]  r_out_value, n_out_value;
    logic                  r_out_last,  n_out_last;

    logic                  accept;
    logic                  conv_start;
    t_conv_out             conv_res;

    logic                  a_we, b_we;
    logic [LSD_IDX_W-1:0]  ram_waddr;
    t_entry                ram_wdata;
    logic [LSD_IDX_W-1:0]  ram_raddr;
    t_entry                a_rdata, b_rdata, rd_entry;
    logic [LSD_DIG_W-1:0]  rd_dig;
    logic [LSD_CNT_W-1:0]  scat_pos;
    logic                  buf_full;

    assign accept     = i_start && !o_busy;
    assign buf_full   = (r_count == LSD_CNT_W'(LSD_MAX_ITEMS));
    assign conv_start = accept && !buf_full;
    assign rd_entry   = r_src ? b_rdata : a_rdata;
    assign rd_dig     = rd_entry.bcd[{r_pass, 2'b00} +: LSD_DIG_W];
    assign scat_pos   = r_cnt[rd_dig] - LSD_CNT_W'(1);

    // Decimal digits of each loaded value.
    lsd_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_value (i_value),
        .o_res   (conv_res)
    );

    // Ping-pong buffers: a pass reads one and scatters into the other.
    lsd_ram #(
        .Width ($bits(t_entry)),
        .Depth (LSD_MAX_ITEMS)
    ) u_buf_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (a_rdata)
    );

    lsd_ram #(
        .Width ($bits(t_entry)),
        .Depth (LSD_MAX_ITEMS)
    ) u_buf_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (b_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!buf_full) begin
                        n_state = S_CONV;
                    end else if (i_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CONV: begin
                if (conv_res.done) begin
                    n_state = r_last ? S_CHECK : S_IDLE;
                end
            end
            S_CHECK: begin
                n_state = (r_pass == r_max_dig) ? S_OUT : S_COUNT;
            end
            S_COUNT: begin
                if (r_idx == r_count) begin
                    n_state = S_PREFIX;
                end
            end
            S_PREFIX: begin
                if (r_j == LSD_PASS_W'(LSD_RADIX - 1)) begin
                    n_state = S_SCATTER;
                end
            end
            S_SCATTER: begin
                if (r_idx == '0) begin
                    n_state = S_CHECK;
                end
            end
            S_OUT: begin
                if (r_idx == r_count) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Buffer port control and the busy flag.
    always_comb begin
        o_busy    = (r_state != S_IDLE);
        a_we      = 1'b0;
        b_we      = 1'b0;
        ram_waddr = r_count[LSD_IDX_W-1:0];
        ram_wdata = '{bcd: conv_res.bcd, value: r_value};
        ram_raddr = r_idx[LSD_IDX_W-1:0];
        case (r_state)
            S_CONV: begin
                a_we = conv_res.done;
            end
            S_SCATTER: begin
                ram_waddr = scat_pos[LSD_IDX_W-1:0];
                ram_wdata = rd_entry;
                a_we      = r_pend && r_src;
                b_we      = r_pend && !r_src;
                ram_raddr = LSD_IDX_W'(r_idx - LSD_CNT_W'(1));
            end
            default: begin
                ram_raddr = r_idx[LSD_IDX_W-1:0];
            end
        endcase
    end

    // Sequencer datapath.
    always_comb begin
        n_count     = r_count;
        n_max_dig   = r_max_dig;
        n_last      = r_last;
        n_value     = r_value;
        n_pass      = r_pass;
        n_src       = r_src;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_j         = r_j;
        n_run       = r_run;
        n_cnt       = r_cnt;
        n_out_valid = 1'b0;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        case (r_state)
            // Capture the load transaction.
            S_IDLE: begin
                if (accept) begin
                    n_last  = i_last;
                    n_value = i_value;
                end
            end
            // Store the value once its digits are known.
            S_CONV: begin
                if (conv_res.done) begin
                    n_count = r_count + LSD_CNT_W'(1);
                    if (conv_res.ndig > r_max_dig) begin
                        n_max_dig = conv_res.ndig;
                    end
                end
            end
            // Start a pass, or the output once every digit is done.
            S_CHECK: begin
                for (int d = 0; d < LSD_RADIX; d++) begin
                    n_cnt[d] = '0;
                end
                n_idx  = '0;
                n_pend = 1'b0;
                n_j    = '0;
                n_run  = '0;
            end
            // Histogram of the current digit.
            S_COUNT: begin
                if (r_pend) begin
                    n_cnt[rd_dig] = r_cnt[rd_dig] + LSD_CNT_W'(1);
                end
                if (r_idx != r_count) begin
                    n_idx  = r_idx + LSD_CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            // Inclusive prefix sums, one digit per cycle.
            S_PREFIX: begin
                n_run    = r_run + r_cnt[r_j];
                n_cnt[r_j] = r_run + r_cnt[r_j];
                n_j      = r_j + LSD_PASS_W'(1);
            end
            // Stable backward scatter into the other buffer.
            S_SCATTER: begin
                if (r_pend) begin
                    n_cnt[rd_dig] = scat_pos;
                end
                if (r_idx != '0) begin
                    n_idx  = r_idx - LSD_CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    n_src  = !r_src;
                    n_pass = r_pass + LSD_PASS_W'(1);
                end
            end
            // Stream the sorted set out, then make ready for a new set.
            S_OUT: begin
                if (r_pend) begin
                    n_out_valid = 1'b1;
                    n_out_value = rd_entry.value;
                    n_out_last  = (r_idx == r_count);
                end
                if (r_idx != r_count) begin
                    n_idx  = r_idx + LSD_CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend    = 1'b0;
                    n_idx     = '0;
                    n_count   = '0;
                    n_max_dig = '0;
                    n_pass    = '0;
                    n_src     = 1'b0;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_dig   <= '0;
            r_last      <= 1'b0;
            r_pass      <= '0;
            r_src       <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_j         <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            for (int d = 0; d < LSD_RADIX; d++) begin
                r_cnt[d] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_max_dig   <= n_max_dig;
            r_last      <= n_last;
            r_pass      <= n_pass;
            r_src       <= n_src;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_j         <= n_j;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_value     <= n_value;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;

    // A result only follows a cycle in which the block was working.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without preceding work");

    // The pass index never runs past the digit count of the largest value.
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass <= r_max_dig)
        else $error("pass index beyond digit count");

    // The fill count never exceeds the buffer depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LSD_CNT_W'(LSD_MAX_ITEMS))
        else $error("fill count beyond buffer depth");

    // Every scattered entry finds a slot left for its digit.
    a_scatter_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCATTER && r_pend) |-> (r_cnt[rd_dig] != '0))
        else $error("scatter with an exhausted digit counter");

endmodule

`default_nettype wire
